// ===== src/sfr_pkg.sv =====
`timescale 1ns / 1ps

package sfr_pkg;

  // parser phases
  typedef enum logic [2:0] {
    PH_HUNT   = 3'd0,
    PH_ID     = 3'd1,
    PH_LEN_HI = 3'd2,
    PH_LEN_LO = 3'd3,
    PH_DATA   = 3'd4,
    PH_CRC_HI = 3'd5,
    PH_CRC_LO = 3'd6
  } phase_t;

  // kind of a result request
  typedef enum logic [1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_GOOD    = 2'd1,
    KIND_BADCRC  = 2'd2,
    KIND_TIMEOUT = 2'd3
  } kind_t;

  // input command codes
  localparam logic CMD_BYTE = 1'b0;
  localparam logic CMD_IDLE = 1'b1;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_SYNC_BYTE    = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDLE_TIMEOUT = 8'd1;

  localparam logic [7:0]  SYNC_RESET    = 8'h55;
  localparam logic [7:0]  TIMEOUT_RESET = 8'd3;
  localparam logic [15:0] CRC_INIT      = 16'hFFFF;
  localparam logic [15:0] CRC_POLY      = 16'hA001;
  localparam logic [7:0]  IDLE_MAX      = 8'hFF;

  // one result request from the parser
  typedef struct packed {
    logic        valid;
    kind_t       kind;
    logic [7:0]  frame_id;
    logic [7:0]  payload_byte;
    logic [15:0] payload_length;
    logic [15:0] computed_crc;
    logic        last;
  } result_t;

  // crc-16/modbus update by one byte, lsb first
  function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

// ===== src/sfr_parser.sv =====
`timescale 1ns / 1ps

module sfr_parser (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  input  logic             command,
  input  logic [7:0]       rx_byte,
  input  logic [7:0]       sync_byte,
  input  logic [7:0]       idle_timeout,
  output sfr_pkg::result_t result
);
  import sfr_pkg::*;

  phase_t      phase, phase_next;
  logic [15:0] bytes_left, bytes_left_next;
  logic [7:0]  current_id, current_id_next;
  logic [15:0] announced_length, announced_length_next;
  logic [15:0] running_crc, running_crc_next;
  logic [7:0]  crc_high, crc_high_next;
  logic [7:0]  idle_count, idle_count_next;

  logic        in_frame;
  logic        timed_out;
  logic [7:0]  idle_inc;
  logic [15:0] crc_upd;
  logic [15:0] len_full;
  logic [15:0] left_dec;
  logic [15:0] got_crc;

  // shared datapath terms
  assign crc_upd   = crc_feed(running_crc, rx_byte);
  assign len_full  = {announced_length[15:8], rx_byte};
  assign left_dec  = bytes_left - 16'd1;
  assign got_crc   = {crc_high, rx_byte};
  assign idle_inc  = (idle_count == IDLE_MAX) ? idle_count : idle_count + 8'd1;
  assign timed_out = in_frame && (idle_inc > idle_timeout);

  // frame in progress
  always_comb begin
    case (phase)
      PH_ID, PH_LEN_HI, PH_LEN_LO, PH_DATA, PH_CRC_HI, PH_CRC_LO: in_frame = 1'b1;
      default:                                                   in_frame = 1'b0;
    endcase
  end

  // next phase
  always_comb begin
    phase_next = phase;
    if (command == CMD_IDLE) begin
      if (timed_out) begin
        phase_next = PH_HUNT;
      end
    end else begin
      unique case (phase)
        PH_ID:     phase_next = PH_LEN_HI;
        PH_LEN_HI: phase_next = PH_LEN_LO;
        PH_LEN_LO: phase_next = (len_full == 16'd0) ? PH_CRC_HI : PH_DATA;
        PH_DATA:   phase_next = (left_dec == 16'd0) ? PH_CRC_HI : PH_DATA;
        PH_CRC_HI: phase_next = PH_CRC_LO;
        PH_CRC_LO: phase_next = PH_HUNT;
        default:   phase_next = (rx_byte == sync_byte) ? PH_ID : PH_HUNT;
      endcase
    end
  end

  // datapath updates and result request
  always_comb begin
    bytes_left_next       = bytes_left;
    current_id_next       = current_id;
    announced_length_next = announced_length;
    running_crc_next      = running_crc;
    crc_high_next         = crc_high;
    idle_count_next       = idle_count;
    result                = '0;
    result.frame_id       = current_id;
    result.payload_length = announced_length;
    if (command == CMD_IDLE) begin
      idle_count_next = idle_inc;
      if (timed_out) begin
        result.valid        = 1'b1;
        result.kind         = KIND_TIMEOUT;
        result.computed_crc = running_crc;
        result.last         = 1'b1;
      end
    end else begin
      idle_count_next = '0;
      unique case (phase)
        PH_ID: begin
          current_id_next  = rx_byte;
          running_crc_next = crc_upd;
        end
        PH_LEN_HI: begin
          announced_length_next = {rx_byte, 8'h00};
          running_crc_next      = crc_upd;
        end
        PH_LEN_LO: begin
          announced_length_next = len_full;
          bytes_left_next       = len_full;
          running_crc_next      = crc_upd;
        end
        PH_DATA: begin
          running_crc_next    = crc_upd;
          bytes_left_next     = left_dec;
          result.valid        = 1'b1;
          result.kind         = KIND_PAYLOAD;
          result.payload_byte = rx_byte;
        end
        PH_CRC_HI: begin
          crc_high_next = rx_byte;
        end
        PH_CRC_LO: begin
          result.valid        = 1'b1;
          result.kind         = (got_crc == running_crc) ? KIND_GOOD : KIND_BADCRC;
          result.computed_crc = running_crc;
          result.last         = 1'b1;
        end
        default: begin
          if (rx_byte == sync_byte) begin
            running_crc_next      = crc_feed(CRC_INIT, rx_byte);
            current_id_next       = '0;
            announced_length_next = '0;
            bytes_left_next       = '0;
          end
        end
      endcase
    end
    if (!item_valid) begin
      result.valid = 1'b0;
    end
  end

  // parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_HUNT;
      bytes_left       <= '0;
      current_id       <= '0;
      announced_length <= '0;
      running_crc      <= CRC_INIT;
      crc_high         <= '0;
      idle_count       <= '0;
    end else if (item_valid) begin
      phase            <= phase_next;
      bytes_left       <= bytes_left_next;
      current_id       <= current_id_next;
      announced_length <= announced_length_next;
      running_crc      <= running_crc_next;
      crc_high         <= crc_high_next;
      idle_count       <= idle_count_next;
    end
  end

endmodule

// ===== src/serial_frame_receiver_crc16.sv =====
`timescale 1ns / 1ps

// Framed serial receiver with CRC-16/MODBUS check. Each input request is a bus
// byte (tuser 0) or one idle tick (tuser 1). The block hunts for the sync byte,
// then reads an id byte, a big-endian 16-bit length, the payload and a CRC sent
// high byte first; the CRC covers sync, id, length and payload. Payload bytes
// leave cut-through as they arrive, and each frame ends with a status request
// (good, CRC mismatch or idle timeout) marked by tlast. A zero length skips
// straight to the CRC bytes. One input request is taken per clock: the parser
// updates its state in the accepting cycle and the result sits in a single
// output register, so input is taken whenever that register is empty or being
// drained. It presents the result in the next cycle. Configuration writes are
// always accepted and should only be issued while the block is idle.
module serial_frame_receiver_crc16 (
  input  logic                          clk,
  input  logic                          rst,
  // input stream
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [7:0]                    s_tdata,   // rx_byte[7:0]
  input  logic                          s_tuser,   // command[0]
  // output stream
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [47:0]                   m_tdata,   // frame_id[7:0], payload_byte[15:8],
                                                   // payload_length[31:16],
                                                   // computed_crc[47:32]
  output logic [1:0]                    m_tuser,   // out_kind[1:0]
  output logic                          m_tlast,   // last
  // configuration write channel
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [sfr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                    cfg_data
);
  import sfr_pkg::*;

  logic       sync_byte;
  logic [7:0] sync_value;
  logic [7:0] idle_timeout;
  logic       in_accept;
  result_t    result;
  result_t    out_reg;

  // configuration registers
  assign cfg_ready = 1'b1;
  assign sync_byte = cfg_valid && (cfg_index == CFG_SYNC_BYTE);

  always_ff @(posedge clk) begin
    if (rst) begin
      sync_value   <= SYNC_RESET;
      idle_timeout <= TIMEOUT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      if (sync_byte) begin
        sync_value <= cfg_data;
      end else if (cfg_index == CFG_IDLE_TIMEOUT) begin
        idle_timeout <= cfg_data;
      end
    end
  end

  // input request taken while the output register is free or draining
  assign s_tready  = !out_reg.valid || m_tready;
  assign in_accept = s_tvalid && s_tready;

  sfr_parser u_parser (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (in_accept),
    .command      (s_tuser),
    .rx_byte      (s_tdata),
    .sync_byte    (sync_value),
    .idle_timeout (idle_timeout),
    .result       (result)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_reg <= '0;
    end else if (in_accept) begin
      out_reg <= result;
    end else if (m_tready) begin
      out_reg.valid <= 1'b0;
    end
  end

  assign m_tvalid = out_reg.valid;
  assign m_tuser  = out_reg.kind;
  assign m_tlast  = out_reg.last;
  assign m_tdata  = {out_reg.computed_crc, out_reg.payload_length,
                     out_reg.payload_byte, out_reg.frame_id};

endmodule
